// ===== rtl/cfws_pkg.sv =====
package cfws_pkg;

    localparam int unsigned DEPTH  = 16;
    localparam int unsigned ADDR_W = $clog2(DEPTH);
    localparam int unsigned CAP_W  = 5;
    localparam int unsigned OP_W   = 3;
    localparam int unsigned VAL_W  = 32;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(DEPTH);

    localparam logic [OP_W-1:0] OP_ENQ    = 3'd0;
    localparam logic [OP_W-1:0] OP_DEQ    = 3'd1;
    localparam logic [OP_W-1:0] OP_PEEK   = 3'd2;
    localparam logic [OP_W-1:0] OP_CLEAR  = 3'd3;
    localparam logic [OP_W-1:0] OP_SEARCH = 3'd4;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef struct packed {
        logic [OP_W-1:0]         op;
        logic signed [VAL_W-1:0] value;
    } t_in_item;

    typedef struct packed {
        t_status                 status;
        logic signed [VAL_W-1:0] data_out;
        logic                    found;
        logic                    is_empty;
        logic                    is_full;
    } t_out_item;

endpackage

// ===== rtl/cfws_ram.sv =====
module cfws_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/circular_fifo_with_search_unit.sv =====
// order: enqueue, clear, refused and unused ops go from idle to done; dequeue and peek pass
// through read, and search through scan once for each of the k entries compared
// (1 up to capacity, one entry a cycle through the single ram read port and comparator)
// throughput: one item at a time, the next is taken once the result is in the output register
// reset (synchronous, active low): queue empty, both pointers 0, capacity 16, no item held
module circular_fifo_with_search_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  cfws_pkg::t_in_item            i_in_item,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output cfws_pkg::t_out_item           o_out_item,
    input  logic                          i_cfg_we,
    input  logic [cfws_pkg::CAP_W-1:0]    i_cfg_data
);

    import cfws_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_SCAN,
        S_DONE
    } t_state;

    t_state                  r_state, n_state;
    logic [ADDR_W-1:0]       r_head, n_head;
    logic [ADDR_W-1:0]       r_tail, n_tail;
    logic                    r_empty, n_empty;
    logic [CAP_W-1:0]        r_cap, n_cap;
    logic [ADDR_W-1:0]       r_idx, n_idx;
    logic                    r_last, n_last;
    logic signed [VAL_W-1:0] r_key, n_key;
    logic [OP_W-1:0]         r_op, n_op;
    t_out_item               r_res, n_res;
    logic                    r_out_valid, n_out_valid;
    t_out_item               r_out, n_out;

    logic                    in_acc;
    logic                    full;
    logic [ADDR_W-1:0]       head_adv, tail_adv, idx_adv;
    logic                    ram_we;
    logic [ADDR_W-1:0]       ram_waddr, ram_raddr;
    logic [VAL_W-1:0]        ram_wdata, ram_q;

    function automatic logic [ADDR_W-1:0] adv(input logic [ADDR_W-1:0] i,
                                              input logic [CAP_W-1:0] cap);
        logic [CAP_W-1:0] n;
        n = CAP_W'(i) + CAP_W'(1);
        return (n >= cap) ? '0 : n[ADDR_W-1:0];
    endfunction

    function automatic logic [CAP_W-1:0] eff_cap(input logic [CAP_W-1:0] c);
        logic [CAP_W-1:0] e;
        e = c;
        if (c == '0) begin
            e = CAP_W'(1);
        end else if (c > CAP_W'(DEPTH)) begin
            e = CAP_W'(DEPTH);
        end
        return e;
    endfunction

    assign in_acc     = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != S_IDLE);
    assign full       = !r_empty && (r_head == r_tail);
    assign head_adv   = adv(r_head, r_cap);
    assign tail_adv   = adv(r_tail, r_cap);
    assign idx_adv    = adv(r_idx, r_cap);

    cfws_ram #(
        .WIDTH (VAL_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_q)
    );

    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_tail      = r_tail;
        n_empty     = r_empty;
        n_cap       = r_cap;
        n_idx       = r_idx;
        n_last      = r_last;
        n_key       = r_key;
        n_op        = r_op;
        n_res       = r_res;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        ram_we      = 1'b0;
        ram_waddr   = r_tail;
        ram_wdata   = i_in_item.value;
        ram_raddr   = r_head;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_op  = i_in_item.op;
                    n_key = i_in_item.value;
                    n_res = '0;
                    n_res.status = ST_DONE;
                    n_state = S_DONE;
                    unique case (i_in_item.op) inside
                        OP_ENQ: begin
                            if (full) begin
                                n_res.status = ST_FULL;
                            end else begin
                                ram_we  = 1'b1;
                                n_tail  = tail_adv;
                                n_empty = 1'b0;
                            end
                        end
                        OP_DEQ, OP_PEEK: begin
                            if (r_empty) begin
                                n_res.status = ST_EMPTY;
                            end else begin
                                n_state = S_READ;
                            end
                        end
                        OP_CLEAR: begin
                            if (r_empty) begin
                                n_res.status = ST_EMPTY;
                            end else begin
                                n_head  = '0;
                                n_tail  = '0;
                                n_empty = 1'b1;
                            end
                        end
                        OP_SEARCH: begin
                            if (r_empty) begin
                                n_res.status = ST_EMPTY;
                            end else begin
                                n_idx   = head_adv;
                                n_last  = (head_adv == r_tail);
                                n_state = S_SCAN;
                            end
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_READ: begin
                n_res.data_out = ram_q;
                if (r_op == OP_DEQ) begin
                    n_head = head_adv;
                    if (head_adv == r_tail) begin
                        n_empty = 1'b1;
                    end
                end
                n_state = S_DONE;
            end
            S_SCAN: begin
                ram_raddr = r_idx;
                if (ram_q == r_key) begin
                    n_res.found = 1'b1;
                    n_state     = S_DONE;
                end else if (r_last) begin
                    n_state = S_DONE;
                end else begin
                    n_idx  = idx_adv;
                    n_last = (idx_adv == r_tail);
                end
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid    = 1'b1;
                    n_out          = r_res;
                    n_out.is_empty = r_empty;
                    n_out.is_full  = full;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // capacity write empties the queue
        if (i_cfg_we) begin
            n_cap   = eff_cap(i_cfg_data);
            n_head  = '0;
            n_tail  = '0;
            n_empty = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_tail      <= '0;
            r_empty     <= 1'b1;
            r_cap       <= CAP_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_empty     <= n_empty;
            r_cap       <= n_cap;
            r_out_valid <= n_out_valid;
        end
        r_idx  <= n_idx;
        r_last <= n_last;
        r_key  <= n_key;
        r_op   <= n_op;
        r_res  <= n_res;
        r_out  <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (CAP_W'(r_head) < r_cap) && (CAP_W'(r_tail) < r_cap))
        else $error("pointer beyond capacity");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_empty |-> (r_head == r_tail))
        else $error("empty queue with unequal pointers");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !ram_we)
        else $error("ram write outside idle");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> !r_empty)
        else $error("search walking an empty queue");

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import cfws_pkg::*;

    localparam logic [OP_W-1:0] OP_SPARE_A = 3'd5;
    localparam logic [OP_W-1:0] OP_SPARE_B = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_C = 3'd7;

    logic             i_clk = 1'b0;
    logic             i_rst_n;
    logic             i_in_valid;
    logic             o_in_stall;
    t_in_item         i_in_item;
    logic             o_out_valid;
    logic             i_out_stall = 1'b0;
    t_out_item        o_out_item;
    logic             i_cfg_we;
    logic [CAP_W-1:0] i_cfg_data;

    // shadow copy of the queue
    logic signed [VAL_W-1:0] ring_words [DEPTH];
    int unsigned             head_slot;
    int unsigned             tail_slot;
    bit                      ring_empty;
    logic [CAP_W-1:0]        cap_setting;

    t_out_item   pending_results [$];
    int unsigned mismatch_count;
    int unsigned sender_idle_pct;
    int unsigned stall_pct;

    circular_fifo_with_search_unit u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    function automatic int unsigned usable_slots();
        if (cap_setting == 0) begin
            return 1;
        end
        if (cap_setting > DEPTH) begin
            return DEPTH;
        end
        return cap_setting;
    endfunction

    function automatic int unsigned next_slot(input int unsigned slot);
        return (slot + 1 >= usable_slots()) ? 0 : slot + 1;
    endfunction

    function automatic bit ring_full();
        return !ring_empty && head_slot == tail_slot;
    endfunction

    function automatic t_out_item fifo_outcome(input t_in_item it);
        t_out_item   res;
        int unsigned slot;
        res = '0;
        res.status = ST_DONE;
        case (it.op)
            OP_ENQ: begin
                if (ring_full()) begin
                    res.status = ST_FULL;
                end else begin
                    ring_words[tail_slot] = it.value;
                    tail_slot = next_slot(tail_slot);
                    ring_empty = 1'b0;
                end
            end
            OP_DEQ, OP_PEEK: begin
                if (ring_empty) begin
                    res.status = ST_EMPTY;
                end else begin
                    res.data_out = ring_words[head_slot];
                    if (it.op == OP_DEQ) begin
                        head_slot = next_slot(head_slot);
                        if (head_slot == tail_slot) begin
                            ring_empty = 1'b1;
                        end
                    end
                end
            end
            OP_CLEAR: begin
                if (ring_empty) begin
                    res.status = ST_EMPTY;
                end else begin
                    head_slot = 0;
                    tail_slot = 0;
                    ring_empty = 1'b1;
                end
            end
            OP_SEARCH: begin
                if (ring_empty) begin
                    res.status = ST_EMPTY;
                end else begin
                    slot = head_slot;
                    for (int unsigned k = 0; k < usable_slots(); k++) begin
                        if (ring_words[slot] == it.value) begin
                            res.found = 1'b1;
                            break;
                        end
                        slot = next_slot(slot);
                        if (slot == tail_slot) begin
                            break;
                        end
                    end
                end
            end
            default: begin
            end
        endcase
        res.is_empty = ring_empty;
        res.is_full = ring_full();
        return res;
    endfunction

    // result checker
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                mismatch_count++;
                $display("%0t expected no item", $time);
                $display("%0t actual   status=%0d data=%0d found=%0b empty=%0b full=%0b",
                         $time, o_out_item.status, o_out_item.data_out, o_out_item.found,
                         o_out_item.is_empty, o_out_item.is_full);
            end else begin
                want = pending_results.pop_front();
                if (o_out_item.status !== want.status || o_out_item.data_out !== want.data_out
                        || o_out_item.found !== want.found
                        || o_out_item.is_empty !== want.is_empty
                        || o_out_item.is_full !== want.is_full) begin
                    mismatch_count++;
                    $display("%0t expected status=%0d data=%0d found=%0b empty=%0b full=%0b",
                             $time, want.status, want.data_out, want.found,
                             want.is_empty, want.is_full);
                    $display("%0t actual   status=%0d data=%0d found=%0b empty=%0b full=%0b",
                             $time, o_out_item.status, o_out_item.data_out,
                             o_out_item.found, o_out_item.is_empty, o_out_item.is_full);
                end
            end
        end
    end

    task automatic send_item(input logic [OP_W-1:0] op, input logic signed [VAL_W-1:0] value);
        t_in_item it;
        it.op = op;
        it.value = value;
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item <= it;
        do begin
            @(posedge i_clk);
        end while (o_in_stall);
        pending_results.push_back(fifo_outcome(it));
    endtask

    task automatic write_capacity(input logic [CAP_W-1:0] cap);
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (4) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_data <= cap;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        cap_setting = cap;
        head_slot = 0;
        tail_slot = 0;
        ring_empty = 1'b1;
    endtask

    task automatic test_empty_queue();
        send_item(OP_DEQ, 32'sd17);
        send_item(OP_PEEK, 32'sd0);
        send_item(OP_SEARCH, 32'sd0);
        send_item(OP_CLEAR, $urandom);
        send_item(OP_SPARE_A, $urandom);
        send_item(OP_SPARE_B, $urandom);
        send_item(OP_SPARE_C, $urandom);
    endtask

    task automatic test_word_extremes();
        send_item(OP_ENQ, 32'sh7fffffff);
        send_item(OP_ENQ, 32'sh80000000);
        send_item(OP_ENQ, 32'sd0);
        send_item(OP_ENQ, -32'sd1);
        send_item(OP_PEEK, 32'sd0);
        send_item(OP_SEARCH, 32'sh80000000);
        send_item(OP_SEARCH, 32'sd12345);
        send_item(OP_DEQ, 32'sd0);
        send_item(OP_CLEAR, 32'sd0);
    endtask

    // two-entry queue: full refusal, search and wrap of both pointers
    task automatic test_wrap_at_capacity();
        write_capacity(5'd2);
        send_item(OP_ENQ, 32'sd101);
        send_item(OP_ENQ, 32'sd202);
        send_item(OP_ENQ, 32'sd303);
        send_item(OP_SEARCH, 32'sd202);
        send_item(OP_DEQ, 32'sd0);
        send_item(OP_ENQ, 32'sd404);
        send_item(OP_DEQ, 32'sd0);
        send_item(OP_DEQ, 32'sd0);
        send_item(OP_DEQ, 32'sd0);
    endtask

    task automatic test_random_traffic();
        logic [CAP_W-1:0]        cap_plan [12] = '{5'd16, 5'd0, 5'd31, 5'd1, 5'd17, 5'd2,
                                                   5'd16, 5'd5, 5'd9, 5'd15, 5'd3, 5'd16};
        logic signed [VAL_W-1:0] word_pool [8];
        logic [OP_W-1:0]         op;
        logic signed [VAL_W-1:0] value;
        int unsigned             fill_bias;
        int unsigned             roll;
        word_pool[0] = 32'sh7fffffff;
        word_pool[1] = 32'sh80000000;
        word_pool[2] = 32'sd0;
        word_pool[3] = -32'sd1;
        for (int p = 4; p < 8; p++) begin
            word_pool[p] = $urandom;
        end
        fill_bias = 50;
        for (int phase = 0; phase < 12; phase++) begin
            write_capacity(cap_plan[phase]);
            case (phase % 4)
                0: begin sender_idle_pct = 0;  stall_pct = 0;  end
                1: begin sender_idle_pct = 70; stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  stall_pct = 70; end
                default: begin sender_idle_pct = 30; stall_pct = 30; end
            endcase
            for (int n = 0; n < 136; n++) begin
                // a new random fill bias every 24 items gives filling and draining bursts
                if (n % 24 == 0) begin
                    fill_bias = $urandom_range(20, 75);
                end
                roll = $urandom_range(0, 99);
                if (roll < fill_bias) begin
                    op = OP_ENQ;
                end else begin
                    roll = $urandom_range(0, 99);
                    if (roll < 40) begin
                        op = OP_DEQ;
                    end else if (roll < 58) begin
                        op = OP_PEEK;
                    end else if (roll < 90) begin
                        op = OP_SEARCH;
                    end else if (roll < 95) begin
                        op = OP_CLEAR;
                    end else if (roll < 97) begin
                        op = OP_SPARE_A;
                    end else if (roll < 99) begin
                        op = OP_SPARE_B;
                    end else begin
                        op = OP_SPARE_C;
                    end
                end
                if ($urandom_range(0, 99) < 60) begin
                    value = word_pool[$urandom_range(0, 7)];
                end else begin
                    value = $urandom;
                end
                send_item(op, value);
            end
        end
    endtask

    initial begin
        #10_000_000;
        $display("tb: failure");
        $finish;
    end

    initial begin
        i_rst_n <= 1'b0;
        i_in_valid <= 1'b0;
        i_in_item <= '0;
        i_cfg_we <= 1'b0;
        i_cfg_data <= '0;
        mismatch_count = 0;
        sender_idle_pct = 0;
        stall_pct = 0;
        cap_setting = CAP_RESET;
        head_slot = 0;
        tail_slot = 0;
        ring_empty = 1'b1;
        for (int s = 0; s < DEPTH; s++) begin
            ring_words[s] = '0;
        end
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_queue();
        test_word_extremes();
        test_wrap_at_capacity();
        test_random_traffic();

        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (30) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// ===== circular_fifo_with_search_unit.f =====
rtl/cfws_pkg.sv
rtl/cfws_ram.sv
rtl/circular_fifo_with_search_unit.sv
sim/testbench.sv
